// ----- rtl/bbfa_pkg.sv -----
// Shared types and constants for the byte buffer bit-field access block.
// Used by bbfa_ram and byte_buffer_bit_field_access; depends on nothing.
package bbfa_pkg;

  // Defaults for the top-level parameters
  localparam int BUFFER_BYTES_DEF   = 256;
  localparam int MAX_FIELD_BITS_DEF = 64;

  // Fixed port field widths
  localparam int OP_W     = 2;
  localparam int IDX_W    = 8;
  localparam int BYTE_W   = 8;
  localparam int OFF_W    = 11;
  localparam int CNT_W    = 7;
  localparam int DATA_W   = 64;
  // A field shifted by up to 7 bits spans at most nine bytes
  localparam int SPAN_W   = DATA_W + BYTE_W;
  localparam int NBYTES_W = 4;

  // Request codes
  typedef logic [OP_W-1:0] op_t;
  localparam op_t OP_LOAD  = 2'd0;
  localparam op_t OP_WRITE = 2'd1;
  localparam op_t OP_READ  = 2'd2;

endpackage

// ----- rtl/bbfa_ram.sv -----
// Generic single write port, single read port RAM with registered read data.
// Depends on bbfa_pkg for the defaults of its parameters.
module bbfa_ram
  import bbfa_pkg::*;
#(
  parameter int WIDTH = BYTE_W,
  parameter int DEPTH = BUFFER_BYTES_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/byte_buffer_bit_field_access.sv -----
// Byte buffer with bit-field insert and extract: top level.
// Depends on bbfa_pkg and bbfa_ram.
//
// A request is one of: byte load, field write, field read. Each request gives
// exactly one result beat (read_value, out_of_range). A byte load, a refused
// request, an empty field or an unused opcode goes from its accept straight to
// ST_FIN, which raises out_valid once any earlier result beat has been taken.
// A field write or read walks the n bytes the field spans (n = 1..9) through
// one byte-wide RAM, one read-modify-write per cycle with the read of the next
// byte overlapped; after the registered read and the last merge, ST_RUN closes
// the walk and ST_FIN raises out_valid. The single RAM read/write port pair
// sets the pace of the walk. in_ready is high only when no request is in work,
// so the next request is taken only after ST_FIN has handed over the result,
// and ST_FIN waits while the previous result beat waits on out_ready.
// After reset the buffer is zeroed by a clearing pass over all BUFFER_BYTES
// bytes, during which in_ready stays low. A field running past the buffer, a
// width above MAX_FIELD_BITS, or a byte index past the end is refused with
// out_of_range set and leaves the buffer unchanged.
module byte_buffer_bit_field_access
  import bbfa_pkg::*;
#(
  parameter int BUFFER_BYTES   = BUFFER_BYTES_DEF,
  parameter int MAX_FIELD_BITS = MAX_FIELD_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  // request channel
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [OP_W-1:0]   in_op,
  input  logic [IDX_W-1:0]  in_byte_index,
  input  logic [BYTE_W-1:0] in_byte_value,
  input  logic [OFF_W-1:0]  in_bit_offset,
  input  logic [CNT_W-1:0]  in_bit_count,
  input  logic [DATA_W-1:0] in_write_value,
  // result channel
  output logic              out_valid,
  input  logic              out_ready,
  output logic [DATA_W-1:0] out_read_value,
  output logic              out_out_of_range
);

  localparam int ADDR_W  = $clog2(BUFFER_BYTES);
  // byte pointer: base up to 255 plus up to nine bytes
  localparam int PTR_W   = 9;
  localparam int AEXT_W  = (ADDR_W > PTR_W) ? ADDR_W : PTR_W;
  localparam int BUF_BITS = BUFFER_BYTES * 8;

  localparam logic [1:0] ST_CLR  = 2'd0;
  localparam logic [1:0] ST_IDLE = 2'd1;
  localparam logic [1:0] ST_RUN  = 2'd2;
  localparam logic [1:0] ST_FIN  = 2'd3;

  // control state
  logic [1:0]          state_r, state_nxt;
  logic [ADDR_W-1:0]   clr_r, clr_nxt;
  logic [NBYTES_W-1:0] rem_r, rem_nxt;
  logic [NBYTES_W-1:0] done_r, done_nxt;
  logic                pend_r, pend_nxt;
  logic                out_valid_r, out_valid_nxt;

  // payload state
  op_t                 op_r, op_nxt;
  logic                flag_r, flag_nxt;
  logic [2:0]          sh_r, sh_nxt;
  logic [PTR_W-1:0]    ptr_r, ptr_nxt;
  logic [ADDR_W-1:0]   wb_addr_r, wb_addr_nxt;
  logic [SPAN_W-1:0]   wval_r, wval_nxt;
  logic [SPAN_W-1:0]   mask_r, mask_nxt;
  logic [SPAN_W-1:0]   acc_r, acc_nxt;
  logic [DATA_W-1:0]   out_read_value_r, out_read_value_nxt;
  logic                out_out_of_range_r, out_out_of_range_nxt;

  // RAM port signals
  logic                ram_we;
  logic [ADDR_W-1:0]   ram_waddr;
  logic [BYTE_W-1:0]   ram_wdata;
  logic [ADDR_W-1:0]   ram_raddr;
  logic [BYTE_W-1:0]   ram_rdata;

  // request decode
  logic                accept;
  logic                idx_ok;
  logic                field_ok;
  logic [AEXT_W-1:0]   idx_ext;
  logic [AEXT_W-1:0]   ptr_ext;
  logic [7:0]          span_bits;
  logic [BYTE_W-1:0]   merged;
  logic                issue;

  bbfa_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (BUFFER_BYTES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_ready         = (state_r == ST_IDLE);
  assign accept           = in_valid & in_ready;
  assign out_valid        = out_valid_r;
  assign out_read_value   = out_read_value_r;
  assign out_out_of_range = out_out_of_range_r;

  // range checks
  assign idx_ok   = (32'(in_byte_index) < BUFFER_BYTES);
  assign field_ok = (32'(in_bit_count) <= MAX_FIELD_BITS) &&
                    ((32'(in_bit_offset) + 32'(in_bit_count)) <= BUF_BITS);

  // bits covered from the first byte boundary, rounded up to whole bytes
  assign span_bits = 8'(in_bit_offset[2:0]) + 8'(in_bit_count) + 8'd7;

  assign idx_ext   = AEXT_W'(in_byte_index);
  assign ptr_ext   = AEXT_W'(ptr_r);
  assign ram_raddr = ptr_ext[ADDR_W-1:0];
  assign issue     = (rem_r != '0);

  // byte merge: keep bits outside the field
  assign merged = (ram_rdata & ~mask_r[BYTE_W-1:0]) |
                  (wval_r[BYTE_W-1:0] & mask_r[BYTE_W-1:0]);

  // sequencer
  always_comb begin
    state_nxt            = state_r;
    clr_nxt              = clr_r;
    rem_nxt              = rem_r;
    done_nxt             = done_r;
    pend_nxt             = 1'b0;
    out_valid_nxt        = out_valid_r;
    op_nxt               = op_r;
    flag_nxt             = flag_r;
    sh_nxt               = sh_r;
    ptr_nxt              = ptr_r;
    wb_addr_nxt          = wb_addr_r;
    wval_nxt             = wval_r;
    mask_nxt             = mask_r;
    acc_nxt              = acc_r;
    out_read_value_nxt   = out_read_value_r;
    out_out_of_range_nxt = out_out_of_range_r;
    ram_we               = 1'b0;
    ram_waddr            = wb_addr_r;
    ram_wdata            = merged;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      // zero the buffer one byte a cycle
      ST_CLR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_r;
        ram_wdata = '0;
        clr_nxt   = clr_r + 1'b1;
        if (clr_r == ADDR_W'(BUFFER_BYTES - 1)) begin
          state_nxt = ST_IDLE;
        end
      end

      // take a request and set up the byte walk
      ST_IDLE: begin
        if (accept) begin
          op_nxt   = in_op;
          sh_nxt   = in_bit_offset[2:0];
          ptr_nxt  = PTR_W'(in_bit_offset[OFF_W-1:3]);
          wval_nxt = SPAN_W'(in_write_value) << in_bit_offset[2:0];
          mask_nxt = (~({SPAN_W{1'b1}} << in_bit_count)) << in_bit_offset[2:0];
          acc_nxt  = '0;
          done_nxt = '0;
          rem_nxt  = '0;
          flag_nxt = 1'b0;
          case (in_op)
            OP_LOAD: begin
              flag_nxt = ~idx_ok;
              if (idx_ok) begin
                ram_we    = 1'b1;
                ram_waddr = idx_ext[ADDR_W-1:0];
                ram_wdata = in_byte_value;
              end
              state_nxt = ST_FIN;
            end
            OP_WRITE, OP_READ: begin
              flag_nxt = ~field_ok;
              if (field_ok && (in_bit_count != '0)) begin
                rem_nxt   = NBYTES_W'(span_bits[7:3]);
                state_nxt = ST_RUN;
              end else begin
                state_nxt = ST_FIN;
              end
            end
            default: begin
              state_nxt = ST_FIN;
            end
          endcase
        end
      end

      // read one byte ahead, merge/gather the byte read last cycle
      ST_RUN: begin
        if (issue) begin
          ptr_nxt     = ptr_r + 1'b1;
          rem_nxt     = rem_r - 1'b1;
          wb_addr_nxt = ram_raddr;
          pend_nxt    = 1'b1;
        end
        if (pend_r) begin
          ram_we   = (op_r == OP_WRITE);
          acc_nxt[8*done_r +: 8] = ram_rdata & mask_r[BYTE_W-1:0];
          done_nxt = done_r + 1'b1;
          wval_nxt = wval_r >> 8;
          mask_nxt = mask_r >> 8;
        end
        if (!issue && !pend_r) begin
          state_nxt = ST_FIN;
        end
      end

      // hand the result to the output register
      ST_FIN: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt        = 1'b1;
          out_out_of_range_nxt = flag_r;
          out_read_value_nxt   = ((op_r == OP_READ) && !flag_r) ?
                                 DATA_W'(acc_r >> sh_r) : '0;
          state_nxt            = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLR;
      clr_r       <= '0;
      rem_r       <= '0;
      done_r      <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      rem_r       <= rem_nxt;
      done_r      <= done_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    op_r               <= op_nxt;
    flag_r             <= flag_nxt;
    sh_r               <= sh_nxt;
    ptr_r              <= ptr_nxt;
    wb_addr_r          <= wb_addr_nxt;
    wval_r             <= wval_nxt;
    mask_r             <= mask_nxt;
    acc_r              <= acc_nxt;
    out_read_value_r   <= out_read_value_nxt;
    out_out_of_range_r <= out_out_of_range_nxt;
  end

endmodule
